// File: rtl/apc_pkg.sv
// Package for the almost prime classifier: field widths, constants and small helpers.
// Used by the sequencer top level; it has no dependencies of its own.

package apc_pkg;

	// Default operand width and reset value of the classification limit.
	localparam int DEF_NUM_BITS = 31;
	localparam int COUNT_W      = 5;
	localparam int SMALL_W      = 16;
	localparam int LARGE_W      = 30;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
	localparam logic [COUNT_W-1:0] MAX_K_RST = 5'd5;
	localparam logic [COUNT_W-1:0] SEMI_CNT  = 5'd2;

	// Wheel step between candidate pairs and the closeness ratio.
	localparam int WHEEL_STEP = 6;
	localparam int CLOSE_MUL  = 100;

	// Saturating increment of the factor count.
	function automatic logic [COUNT_W-1:0] cnt_inc(input logic [COUNT_W-1:0] c);
		cnt_inc = (c == COUNT_MAX) ? c : c + 5'd1;
	endfunction

endpackage

// File: rtl/apc_div.sv
// Bit-serial restoring divider for the almost prime classifier.
// Produces one quotient bit per cycle; depends on no package.

module apc_div #(
	parameter int DVD_W = 31,
	parameter int DVS_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             qbit;
	logic [DVS_W-1:0] rem_n;

	// One restoring step: bring down the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		qbit  = (trial >= {1'b0, dvs_q});
		rem_n = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
	end

	// Control and datapath registers; the quotient shifts in behind the dividend.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
				dvd_q  <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[DVD_W-2:0], qbit};
				rem_q <= rem_n;
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

// File: rtl/almost_prime_classifier.sv
// Top level of the almost prime classifier: command port, sequencer and result registers.
// Depends on apc_pkg and the serial divider apc_div.
//
// Usage: drive number_in and raise start while busy is low; that beat is taken and
// busy rises on the next cycle. The number is factored by trial division (2, 3, then
// 6k-1 and 6k+1 while (6k-1)^2 <= number), every trial going through one shared
// bit-serial divider. A trial is a candidate pick, a divider load, NUM_BITS divider
// steps and a result check; a number of 2^31-1 needs about 15500 trials, while small
// numbers finish in a few trials. For numbers below two the sequencer goes straight to
// its finish state, which registers the result beat. When the
// work is done the result is shown for exactly one cycle with done high; busy is already
// low in that cycle, so a new start can be taken there. The receiver cannot stall; a
// result not taken is gone.
// max_k is written through cfg_valid/cfg_ready (ready is always high) and should only
// change while busy is low. Reset clears the sequencer, drops done and sets max_k to 5.

module almost_prime_classifier #(
	parameter int NUM_BITS = apc_pkg::DEF_NUM_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [NUM_BITS-1:0]         number_in,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [apc_pkg::COUNT_W-1:0] cfg_data,
	output logic                        done,
	output logic [apc_pkg::COUNT_W-1:0] factor_count,
	output logic                        is_semiprime,
	output logic                        is_k_almost,
	output logic                        is_close_semiprime,
	output logic [apc_pkg::SMALL_W-1:0] small_factor,
	output logic [apc_pkg::LARGE_W-1:0] large_factor
);

	localparam int D_W  = (NUM_BITS + 1) / 2 + 1;
	localparam int SQ_W = 2 * D_W;
	localparam int P_W  = NUM_BITS + 7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEXT,
		ST_DIV,
		ST_TAIL,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		PH_TWO,
		PH_THREE,
		PH_LO,
		PH_HI
	} phase_t;

	state_t                      state_q;
	phase_t                      phase_q;
	logic [NUM_BITS-1:0]         n_q;
	logic [NUM_BITS-1:0]         rest_q;
	logic [NUM_BITS-1:0]         q_q;
	logic [D_W-1:0]              first_q;
	logic [D_W-1:0]              cand_q;
	logic [D_W-1:0]              d_q;
	logic [SQ_W-1:0]             sq_q;
	logic [apc_pkg::COUNT_W-1:0] count_q;
	logic [apc_pkg::COUNT_W-1:0] max_k_q;
	logic                        go_q;
	logic                        done_q;
	logic [apc_pkg::COUNT_W-1:0] count_out_q;
	logic                        semi_q;
	logic                        kalm_q;
	logic                        close_q;
	logic [apc_pkg::SMALL_W-1:0] small_q;
	logic [apc_pkg::LARGE_W-1:0] large_q;

	logic                        div_done;
	logic [NUM_BITS-1:0]         div_quo;
	logic [D_W-1:0]              div_rem;

	logic                        accept;
	logic [D_W-1:0]              d_m1;
	logic [SQ_W-1:0]             sq_next;
	logic                        sq_fits;
	logic                        semi;
	logic [NUM_BITS-1:0]         p_ext;
	logic [NUM_BITS-1:0]         qp_diff;
	logic [P_W-1:0]              diff_x100;
	logic                        close;
	logic                        kalm;

	apc_div #(
		.DVD_W(NUM_BITS),
		.DVS_W(D_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go_q),
		.dividend (rest_q),
		.divisor  (cand_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// Wheel bookkeeping: (d+5)^2 = (d-1)^2 + 12(d-1) + 36.
	always_comb begin
		d_m1    = d_q - D_W'(1);
		sq_next = sq_q + (SQ_W'(d_m1) << 3) + (SQ_W'(d_m1) << 2) + SQ_W'(36);
		sq_fits = (sq_q <= SQ_W'(n_q));
	end

	// Classification of the finished count; q - p <= floor(q/100) is 100(q - p) <= q.
	always_comb begin
		semi      = (count_q == apc_pkg::SEMI_CNT);
		p_ext     = NUM_BITS'(first_q);
		qp_diff   = q_q - p_ext;
		diff_x100 = P_W'(qp_diff) * P_W'(apc_pkg::CLOSE_MUL);
		close     = semi && (q_q > p_ext) && (diff_x100 <= P_W'(q_q));
		kalm      = (count_q >= apc_pkg::SEMI_CNT) && (count_q <= max_k_q);
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_k_q <= apc_pkg::MAX_K_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_k_q <= cfg_data;
		end
	end

	// Sequencer: walks the candidate list, one divider run per trial.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_TWO;
			n_q         <= '0;
			rest_q      <= '0;
			q_q         <= '0;
			first_q     <= '0;
			cand_q      <= '0;
			d_q         <= '0;
			sq_q        <= '0;
			count_q     <= '0;
			go_q        <= 1'b0;
			done_q      <= 1'b0;
			count_out_q <= '0;
			semi_q      <= 1'b0;
			kalm_q      <= 1'b0;
			close_q     <= 1'b0;
			small_q     <= '0;
			large_q     <= '0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q     <= number_in;
						rest_q  <= number_in;
						q_q     <= '0;
						first_q <= '0;
						count_q <= '0;
						phase_q <= PH_TWO;
						d_q     <= D_W'(apc_pkg::WHEEL_STEP);
						sq_q    <= SQ_W'(25);
						// Zero and one have no factors at all.
						state_q <= (number_in < NUM_BITS'(2)) ? ST_FIN : ST_NEXT;
					end
				end
				ST_NEXT: begin
					unique case (phase_q)
						PH_TWO: begin
							if (n_q >= NUM_BITS'(4)) begin
								cand_q  <= D_W'(2);
								go_q    <= 1'b1;
								state_q <= ST_DIV;
							end else begin
								phase_q <= PH_THREE;
							end
						end
						PH_THREE: begin
							if (n_q >= NUM_BITS'(9)) begin
								cand_q  <= D_W'(3);
								go_q    <= 1'b1;
								state_q <= ST_DIV;
							end else begin
								phase_q <= PH_LO;
							end
						end
						PH_LO: begin
							if (sq_fits) begin
								cand_q  <= d_m1;
								go_q    <= 1'b1;
								state_q <= ST_DIV;
							end else begin
								state_q <= ST_TAIL;
							end
						end
						PH_HI: begin
							cand_q  <= d_q + D_W'(1);
							go_q    <= 1'b1;
							state_q <= ST_DIV;
						end
						default: begin
							state_q <= ST_TAIL;
						end
					endcase
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_NEXT;
						if (div_rem == '0) begin
							// Factor found: divide it out and try the same candidate again.
							if ((first_q == '0) && (div_quo != NUM_BITS'(1))) begin
								first_q <= cand_q;
								q_q     <= div_quo;
							end
							rest_q  <= div_quo;
							count_q <= apc_pkg::cnt_inc(count_q);
						end else begin
							unique case (phase_q)
								PH_TWO:   phase_q <= PH_THREE;
								PH_THREE: phase_q <= PH_LO;
								PH_LO:    phase_q <= PH_HI;
								PH_HI: begin
									phase_q <= PH_LO;
									d_q     <= d_q + D_W'(apc_pkg::WHEEL_STEP);
									sq_q    <= sq_next;
								end
								default:  phase_q <= PH_LO;
							endcase
						end
					end
				end
				ST_TAIL: begin
					// A leftover cofactor above one is a prime of its own.
					if (rest_q != NUM_BITS'(1)) begin
						count_q <= apc_pkg::cnt_inc(count_q);
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					done_q      <= 1'b1;
					count_out_q <= count_q;
					semi_q      <= semi;
					kalm_q      <= kalm;
					close_q     <= close;
					small_q     <= semi ? apc_pkg::SMALL_W'(first_q) : '0;
					large_q     <= semi ? apc_pkg::LARGE_W'(q_q) : '0;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done               = done_q;
	assign factor_count       = count_out_q;
	assign is_semiprime       = semi_q;
	assign is_k_almost        = kalm_q;
	assign is_close_semiprime = close_q;
	assign small_factor       = small_q;
	assign large_factor       = large_q;

	// A taken command always keeps the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after a taken command");

	// The divider only finishes while the sequencer waits for it.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside a trial");

	// Semiprime flag matches the reported count, and factors are zero otherwise.
	a_semi_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_semiprime == (factor_count == apc_pkg::SEMI_CNT)))
		else $error("semiprime flag disagrees with count");

	a_zero_fac: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !is_semiprime) |-> (small_factor == '0 && large_factor == '0
			&& !is_close_semiprime))
		else $error("factors reported for a non-semiprime");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for almost_prime_classifier: directed and random numbers
// are checked against a trial-division predictor under several max_k settings.
// Depends on apc_pkg and the almost_prime_classifier RTL.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import apc_pkg::*;

	localparam int NUM_BITS = DEF_NUM_BITS;
	// The slowest number (2^31-1) needs about 15500 trials, each a full divider run.
	localparam int STALL_LIMIT = 2_500_000;

	typedef struct {
		logic [COUNT_W-1:0] count;
		logic               semi;
		logic               k_almost;
		logic               close;
		logic [SMALL_W-1:0] small_f;
		logic [LARGE_W-1:0] large_f;
	} class_result_t;

	// Predicts the classification of each accepted number and checks the results.
	class factor_ledger;
		class_result_t expected_q[$];
		int unsigned errors, checked, semis, closes, k_hits, deepest;
		longint unsigned rest_val, first_val;
		int unsigned hits;

		// Divide out every copy of one trial divisor, noting the first real factor.
		function void strip(longint unsigned d);
			while (d > 1 && rest_val % d == 0) begin
				if (first_val == 0 && rest_val / d != 1)
					first_val = d;
				rest_val = rest_val / d;
				hits++;
			end
		endfunction

		function class_result_t classify(logic [NUM_BITS-1:0] num, logic [COUNT_W-1:0] k_limit);
			longint unsigned n, d, p, q;
			class_result_t r;
			n = num;
			rest_val = n;
			first_val = 0;
			hits = 0;
			p = 0;
			q = 0;
			if (n >= 2) begin
				if (n >= 4)
					strip(2);
				if (n >= 9)
					strip(3);
				for (d = WHEEL_STEP; (d - 1) * (d - 1) <= n; d += WHEEL_STEP) begin
					strip(d - 1);
					strip(d + 1);
				end
				// A leftover cofactor is a prime of its own.
				if (rest_val != 1)
					hits++;
			end
			if (hits > COUNT_MAX)
				hits = COUNT_MAX;
			r.count = hits[COUNT_W-1:0];
			r.semi = (hits == SEMI_CNT);
			r.close = 1'b0;
			if (r.semi) begin
				p = first_val;
				q = (p != 0) ? n / p : 0;
				r.close = (q > p) && (q - p <= q / CLOSE_MUL);
			end
			r.k_almost = (hits >= 2) && (hits <= k_limit);
			r.small_f = p[SMALL_W-1:0];
			r.large_f = q[LARGE_W-1:0];
			return r;
		endfunction

		function void note(logic [NUM_BITS-1:0] num, logic [COUNT_W-1:0] k_limit);
			expected_q.push_back(classify(num, k_limit));
		endfunction

		function void compare_field(string name, longint unsigned exp, longint unsigned act);
			if (exp != act) begin
				$error("%s: expected %0d, got %0d", name, exp, act);
				errors++;
			end
		endfunction

		function void check(class_result_t got);
			class_result_t want;
			if (expected_q.size() == 0) begin
				$error("result beat with no number outstanding (count %0d)", got.count);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("factor_count", want.count, got.count);
			compare_field("is_semiprime", want.semi, got.semi);
			compare_field("is_k_almost", want.k_almost, got.k_almost);
			compare_field("is_close_semiprime", want.close, got.close);
			compare_field("small_factor", want.small_f, got.small_f);
			compare_field("large_factor", want.large_f, got.large_f);
			checked++;
			semis += want.semi;
			closes += want.close;
			k_hits += want.k_almost;
			if (want.count > deepest)
				deepest = want.count;
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [NUM_BITS-1:0] number_in = '0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [COUNT_W-1:0]  cfg_data = '0;
	logic                done;
	logic [COUNT_W-1:0]  factor_count;
	logic                is_semiprime;
	logic                is_k_almost;
	logic                is_close_semiprime;
	logic [SMALL_W-1:0]  small_factor;
	logic [LARGE_W-1:0]  large_factor;

	logic [COUNT_W-1:0]  max_k_model = MAX_K_RST;
	bit                  idle_free = 1'b0;
	int unsigned         settings_used = 1;
	int                  stall_cycles = 0;
	factor_ledger        ledger = new();

	// Zero and one, small composites, prime squares, close pairs, high counts, widest.
	logic [NUM_BITS-1:0] directed_nums [22] = '{
		31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd8, 31'd9, 31'd12, 31'd30,
		31'd35, 31'd49, 31'd77, 31'd41989, 31'd51983, 31'd63001, 31'd1022117,
		31'd1594323, 31'd1048576, 31'h4000_0000, 31'h7FFF_FFFF
	};

	almost_prime_classifier #(.NUM_BITS(NUM_BITS)) DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.number_in          (number_in),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_data           (cfg_data),
		.done               (done),
		.factor_count       (factor_count),
		.is_semiprime       (is_semiprime),
		.is_k_almost        (is_k_almost),
		.is_close_semiprime (is_close_semiprime),
		.small_factor       (small_factor),
		.large_factor       (large_factor)
	);

	always #5 clk = ~clk;

	// Check result beats first, then record a newly accepted number.
	always @(posedge clk) begin
		class_result_t got;
		if (arst_n) begin
			if (done) begin
				got.count = factor_count;
				got.semi = is_semiprime;
				got.k_almost = is_k_almost;
				got.close = is_close_semiprime;
				got.small_f = small_factor;
				got.large_f = large_factor;
				ledger.check(got);
			end
			if (start && !busy)
				ledger.note(number_in, max_k_model);
		end
	end

	// Watchdog on cycles in which no beat moves on any port.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("** almost_prime_classifier: FAILED **");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic bit is_prime(longint unsigned n);
		class_result_t r;
		r = ledger.classify(n[NUM_BITS-1:0], '0);
		return r.count == 1;
	endfunction

	function automatic longint unsigned random_prime(int unsigned lo, int unsigned hi);
		longint unsigned n;
		do n = $urandom_range(lo, hi); while (!is_prime(n));
		return n;
	endfunction

	// Mostly small numbers, with built semiprimes, close pairs and smooth products.
	function automatic logic [NUM_BITS-1:0] random_number();
		int unsigned pick;
		longint unsigned n, p, q, f;
		longint unsigned smooth_primes [6] = '{2, 3, 5, 7, 11, 13};
		pick = $urandom_range(0, 19);
		if (pick < 8) begin
			n = $urandom_range(2, 4095);
		end else if (pick < 13) begin
			n = $urandom_range(4096, 1 << 18);
		end else if (pick < 16) begin
			n = random_prime(2, 1000) * random_prime(2, 1000);
		end else if (pick == 16) begin
			q = random_prime(211, 2000);
			p = q - 1;
			while (!is_prime(p))
				p--;
			n = p * q;
		end else if (pick == 17) begin
			n = 1;
			f = smooth_primes[$urandom_range(0, 5)];
			while (n * f < (1 << 21)) begin
				n = n * f;
				f = smooth_primes[$urandom_range(0, 5)];
			end
		end else if (pick == 18) begin
			n = $urandom_range(0, 3);
		end else begin
			n = $urandom_range(1 << 18, 1 << 21);
		end
		return n[NUM_BITS-1:0];
	endfunction

	// Present one number and wait for its beat; start stays high between back-to-back items.
	task automatic issue_number(input logic [NUM_BITS-1:0] n);
		int gap;
		gap = (idle_free || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		number_in <= n;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Hold off new numbers until every outstanding result has come back.
	task automatic settle();
		start <= 1'b0;
		while (ledger.expected_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_max_k(input logic [COUNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		max_k_model = value;
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [COUNT_W-1:0] k_value, input int items, input bit no_gaps);
		settle();
		write_max_k(k_value);
		idle_free = no_gaps;
		repeat (items) begin
			if ($urandom_range(0, 15) == 0)
				settle();
			issue_number(random_number());
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed numbers under the reset value of max_k.
		foreach (directed_nums[i])
			issue_number(directed_nums[i]);

		run_phase(5'd31, 25, 1'b0);
		run_phase(5'd0, 15, 1'b0);
		run_phase(5'd1, 15, 1'b0);
		run_phase(5'd2, 15, 1'b1);
		run_phase(COUNT_W'($urandom_range(3, 30)), 15, 1'b0);

		settle();
		repeat (50) @(posedge clk);
		if (ledger.expected_q.size() != 0) begin
			$error("%0d results never arrived", ledger.expected_q.size());
			ledger.errors++;
		end

		$display("Classified %0d numbers under %0d max_k settings; highest factor count %0d.",
			ledger.checked, settings_used, ledger.deepest);
		$display("Seen: %0d semiprimes, %0d close semiprimes, %0d k-almost primes.",
			ledger.semis, ledger.closes, ledger.k_hits);
		if (ledger.errors == 0) begin
			$display("** almost_prime_classifier: PASSED **");
		end else begin
			$display("** almost_prime_classifier: FAILED **");
		end
		$finish;
	end

endmodule
